// File: rtl/pectrk_pkg.sv
`timescale 1ns / 1ps
package pectrk_pkg;

  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned DELTA_W = 13;

  // Absolute full scale is 2**ABS_SHIFT - 1, so the scale divide is an add and a shift
  localparam int unsigned ABS_FULL_SCALE = 32767;
  localparam int unsigned ABS_SHIFT      = 15;
  localparam int unsigned NUM_W          = ABS_SHIFT + SIZE_W;

  typedef enum logic [1:0] {
    OP_EVENT  = 2'd0,
    OP_MOVE   = 2'd1,
    OP_BUTTON = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } reg_idx_t;

  localparam logic [15:0] TYPE_KEY  = 16'h0001;
  localparam logic [15:0] TYPE_REL  = 16'h0002;
  localparam logic [15:0] TYPE_ABS  = 16'h0003;
  localparam logic [15:0] AXIS_X    = 16'h0000;
  localparam logic [15:0] AXIS_Y    = 16'h0001;
  localparam logic [15:0] KEY_LEFT  = 16'h0110;
  localparam logic [15:0] KEY_RIGHT = 16'h0111;

  localparam logic [SIZE_W-1:0] SIZE_MAX   = 13'd4096;
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd800;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd600;
  localparam logic [POS_W-1:0]  X_RST      = 12'd400;
  localparam logic [POS_W-1:0]  Y_RST      = 12'd300;

  localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic [31:0]        ev_value;
    logic signed [31:0] move_dx;
    logic signed [31:0] move_dy;
    logic               left_press;
  } in_word_t;

  typedef struct packed {
    logic                      motion;
    logic                      x_load;
    logic                      y_load;
    logic                      abs_big;
    logic [NUM_W-1:0]          abs_num;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [1:0]                btn_set;
    logic [1:0]                btn_clr;
  } step_t;

  function automatic logic [SIZE_W-1:0] size_eff(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_MAX) begin
      r = SIZE_MAX;
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] size_top(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] e;
    e = size_eff(s) - SIZE_W'(1);
    return e[POS_W-1:0];
  endfunction

  // A step outside the DELTA_W-bit signed range saturates to DELTA_MIN or DELTA_MAX
  function automatic logic signed [DELTA_W-1:0] sat_delta(input logic [31:0] v);
    logic signed [DELTA_W-1:0] r;
    if (v[31:DELTA_W-1] == {(33-DELTA_W){v[31]}}) begin
      r = v[DELTA_W-1:0];
    end else if (v[31]) begin
      r = DELTA_MIN;
    end else begin
      r = DELTA_MAX;
    end
    return r;
  endfunction

endpackage

// File: rtl/pointer_event_cursor_tracker_unit.sv
`timescale 1ns / 1ps
// Pointer cursor tracker. Each accepted input word (pointer event, inject move or
// inject left button) gives exactly one result word holding the cursor position and
// both button bits after that word. Throughput is one word per cycle while out_ready
// does not stall the pipe; out_valid rises once the word has passed three register stages
// (input register, decode/scale-multiply register, then the cursor state register, which
// is also the result register). The per-cycle rate is set by the cursor add-and-clamp
// loop, which closes in the last stage.
// Screen width and height are written through the cfg channel (index 0 width, 1 height,
// others ignored), always ready, and take effect for motion words written afterwards;
// write them only while no word is in flight.
module pointer_event_cursor_tracker_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_event_type,
  input  logic [15:0] in_event_code,
  input  logic [31:0] in_event_value,
  input  logic signed [31:0] in_move_dx,
  input  logic signed [31:0] in_move_dy,
  input  logic        in_left_press,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_ptr_x,
  output logic [11:0] out_ptr_y,
  output logic        out_left_button,
  output logic        out_right_button,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic [pectrk_pkg::SIZE_W-1:0] width_r, height_r;
  logic [pectrk_pkg::SIZE_W-1:0] eff_w, eff_h;
  logic [pectrk_pkg::POS_W-1:0]  top_w, top_h;

  logic s1_v_r, s2_v_r, out_v_r;
  logic en1, en2, en3;

  pectrk_pkg::in_word_t s1_r, s1_nxt;
  pectrk_pkg::step_t    s2_r, s2_nxt;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= pectrk_pkg::WIDTH_RST;
      height_r <= pectrk_pkg::HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (pectrk_pkg::reg_idx_t'(cfg_index))
        pectrk_pkg::REG_WIDTH:  width_r  <= cfg_data;
        pectrk_pkg::REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_w = pectrk_pkg::size_eff(width_r);
  assign eff_h = pectrk_pkg::size_eff(height_r);
  assign top_w = pectrk_pkg::size_top(width_r);
  assign top_h = pectrk_pkg::size_top(height_r);

  // elastic three-stage pipe; each stage moves when the one ahead is free
  assign en3      = !out_v_r || out_ready;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r  <= in_valid;
      if (en2) s2_v_r  <= s1_v_r;
      if (en3) out_v_r <= s2_v_r;
    end
  end

  assign s1_nxt.op         = in_operation;
  assign s1_nxt.ev_type    = in_event_type;
  assign s1_nxt.ev_code    = in_event_code;
  assign s1_nxt.ev_value   = in_event_value;
  assign s1_nxt.move_dx    = in_move_dx;
  assign s1_nxt.move_dy    = in_move_dy;
  assign s1_nxt.left_press = in_left_press;

  always_ff @(posedge clk) begin
    if (en1 && in_valid) s1_r <= s1_nxt;
    if (en2 && s1_v_r)   s2_r <= s2_nxt;
  end

  pectrk_decode u_decode (
    .word_i  (s1_r),
    .eff_w_i (eff_w),
    .eff_h_i (eff_h),
    .step_o  (s2_nxt)
  );

  pectrk_update u_update (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (en3 && s2_v_r),
    .step_i  (s2_r),
    .top_w_i (top_w),
    .top_h_i (top_h),
    .x_o     (out_ptr_x),
    .y_o     (out_ptr_y),
    .left_o  (out_left_button),
    .right_o (out_right_button)
  );

  assign out_valid = out_v_r;

  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_v_r && s2_v_r && out_v_r && !out_ready)
    else $error("input stalled with a free pipeline slot");

endmodule

// File: rtl/pectrk_decode.sv
`timescale 1ns / 1ps
module pectrk_decode (
  input  pectrk_pkg::in_word_t           word_i,
  input  logic [pectrk_pkg::SIZE_W-1:0]  eff_w_i,
  input  logic [pectrk_pkg::SIZE_W-1:0]  eff_h_i,
  output pectrk_pkg::step_t              step_o
);

  logic [1:0]                    key_bit;
  logic [pectrk_pkg::SIZE_W-1:0] abs_eff;
  logic [pectrk_pkg::NUM_W-1:0]  abs_num;

  // only values below full scale need the product; the rest pin to the edge
  assign abs_eff = (word_i.ev_code == pectrk_pkg::AXIS_Y) ? eff_h_i : eff_w_i;
  assign abs_num = pectrk_pkg::NUM_W'(word_i.ev_value[pectrk_pkg::ABS_SHIFT-1:0])
                 * pectrk_pkg::NUM_W'(abs_eff);

  always_comb begin
    unique case (word_i.ev_code)
      pectrk_pkg::KEY_LEFT:  key_bit = 2'b01;
      pectrk_pkg::KEY_RIGHT: key_bit = 2'b10;
      default:               key_bit = 2'b00;
    endcase
  end

  always_comb begin
    step_o         = '0;
    step_o.abs_num = abs_num;
    step_o.abs_big = (word_i.ev_value >= 32'(pectrk_pkg::ABS_FULL_SCALE));
    unique case (pectrk_pkg::op_t'(word_i.op))
      pectrk_pkg::OP_EVENT: begin
        unique case (word_i.ev_type)
          pectrk_pkg::TYPE_REL: begin
            step_o.motion = 1'b1;
            if (word_i.ev_code == pectrk_pkg::AXIS_X) begin
              step_o.dx = pectrk_pkg::sat_delta(word_i.ev_value);
            end else if (word_i.ev_code == pectrk_pkg::AXIS_Y) begin
              step_o.dy = pectrk_pkg::sat_delta(word_i.ev_value);
            end
          end
          pectrk_pkg::TYPE_ABS: begin
            step_o.motion = 1'b1;
            step_o.x_load = (word_i.ev_code == pectrk_pkg::AXIS_X);
            step_o.y_load = (word_i.ev_code == pectrk_pkg::AXIS_Y);
          end
          pectrk_pkg::TYPE_KEY: begin
            if (word_i.ev_value != '0) begin
              step_o.btn_set = key_bit;
            end else begin
              step_o.btn_clr = key_bit;
            end
          end
          default: ;
        endcase
      end
      pectrk_pkg::OP_MOVE: begin
        step_o.motion = 1'b1;
        step_o.dx     = pectrk_pkg::sat_delta(word_i.move_dx);
        step_o.dy     = pectrk_pkg::sat_delta(word_i.move_dy);
      end
      pectrk_pkg::OP_BUTTON: begin
        if (word_i.left_press) begin
          step_o.btn_set = 2'b01;
        end else begin
          step_o.btn_clr = 2'b01;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/pectrk_update.sv
`timescale 1ns / 1ps
module pectrk_update (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en_i,
  input  pectrk_pkg::step_t             step_i,
  input  logic [pectrk_pkg::POS_W-1:0]  top_w_i,
  input  logic [pectrk_pkg::POS_W-1:0]  top_h_i,
  output logic [pectrk_pkg::POS_W-1:0]  x_o,
  output logic [pectrk_pkg::POS_W-1:0]  y_o,
  output logic                          left_o,
  output logic                          right_o
);

  localparam int unsigned SUM_W = pectrk_pkg::POS_W + 2;
  localparam int unsigned EXT_W = SUM_W - pectrk_pkg::DELTA_W;
  localparam int unsigned Q_LO  = pectrk_pkg::ABS_SHIFT;
  localparam int unsigned Q_HI  = pectrk_pkg::ABS_SHIFT + pectrk_pkg::POS_W - 1;

  logic [pectrk_pkg::POS_W-1:0] x_r, x_nxt;
  logic [pectrk_pkg::POS_W-1:0] y_r, y_nxt;
  logic [1:0]                   btn_r, btn_nxt;

  logic signed [SUM_W-1:0]         sum_x, sum_y;
  logic [pectrk_pkg::NUM_W:0]      q_sum;
  logic [pectrk_pkg::POS_W-1:0]    abs_q, abs_x, abs_y;

  function automatic logic [pectrk_pkg::POS_W-1:0] clamp_pos(
    input logic signed [SUM_W-1:0]      v,
    input logic [pectrk_pkg::POS_W-1:0] top
  );
    logic [pectrk_pkg::POS_W-1:0] r;
    if (v[SUM_W-1]) begin
      r = '0;
    end else if (v[pectrk_pkg::POS_W:0] > {1'b0, top}) begin
      r = top;
    end else begin
      r = v[pectrk_pkg::POS_W-1:0];
    end
    return r;
  endfunction

  assign sum_x = $signed({2'b00, x_r}) + $signed({{EXT_W{step_i.dx[pectrk_pkg::DELTA_W-1]}},
                                                  step_i.dx});
  assign sum_y = $signed({2'b00, y_r}) + $signed({{EXT_W{step_i.dy[pectrk_pkg::DELTA_W-1]}},
                                                  step_i.dy});

  // floor(n / (2^15 - 1)) = (n + (n >> 15) + 1) >> 15, exact while the quotient fits 15 bits
  assign q_sum = {1'b0, step_i.abs_num}
               + (pectrk_pkg::NUM_W + 1)'(step_i.abs_num >> pectrk_pkg::ABS_SHIFT)
               + (pectrk_pkg::NUM_W + 1)'(1);
  assign abs_q = q_sum[Q_HI:Q_LO];
  assign abs_x = step_i.abs_big ? top_w_i : abs_q;
  assign abs_y = step_i.abs_big ? top_h_i : abs_q;

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    btn_nxt = (btn_r | step_i.btn_set) & ~step_i.btn_clr;
    if (step_i.motion) begin
      x_nxt = step_i.x_load ? abs_x : clamp_pos(sum_x, top_w_i);
      y_nxt = step_i.y_load ? abs_y : clamp_pos(sum_y, top_h_i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= pectrk_pkg::X_RST;
      y_r   <= pectrk_pkg::Y_RST;
      btn_r <= 2'b00;
    end else if (en_i) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      btn_r <= btn_nxt;
    end
  end

  assign x_o     = x_r;
  assign y_o     = y_r;
  assign left_o  = btn_r[0];
  assign right_o = btn_r[1];

  a_x_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    en_i && step_i.motion |=> x_r <= $past(top_w_i))
    else $error("cursor x beyond screen after motion");

  a_y_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    en_i && step_i.motion |=> y_r <= $past(top_h_i))
    else $error("cursor y beyond screen after motion");

  a_no_motion_holds: assert property (@(posedge clk) disable iff (!rst_n)
    en_i && !step_i.motion |=> $stable(x_r) && $stable(y_r))
    else $error("cursor moved on a button word");

  a_abs_edge: assert property (@(posedge clk) disable iff (!rst_n)
    en_i && step_i.x_load && step_i.abs_big |=> x_r == $past(top_w_i))
    else $error("absolute x at full scale not pinned to right edge");

endmodule
